FILE: hdl/assert_macros.svh
// assertion macros shared by the interval cover design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GIC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interval cover assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define GIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interval cover assertion failed");

`endif

FILE: hdl/gic_pkg.sv
// types and constants of the greedy interval cover
package gic_pkg;

    localparam int NUM_CELLS = 64;
    localparam int DATA_W    = 16;
    localparam int CNT_W     = $clog2(NUM_CELLS + 1);
    localparam int STEP_W    = $clog2(NUM_CELLS);

    typedef struct packed {
        logic signed [DATA_W-1:0] start_pt;
        logic signed [DATA_W-1:0] end_pt;
    } interval_t;

    typedef struct packed {
        logic      found;
        interval_t iv;
    } token_t;

    typedef struct packed {
        logic                     clear;
        logic signed [DATA_W-1:0] reach;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE
    } state_t;

endpackage

FILE: hdl/gic_cell.sv
// one cell of the interval chain: holds an interval and refines the passing best token
module gic_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             shift_en,
    input  logic                             occupied,
    input  logic signed [gic_pkg::DATA_W-1:0] reach,
    input  gic_pkg::interval_t               data_in,
    output gic_pkg::interval_t               data_out,
    input  gic_pkg::token_t                  tok_in,
    output gic_pkg::token_t                  tok_out
);

    gic_pkg::interval_t data_reg;
    logic               found_reg;
    gic_pkg::interval_t best_reg;
    gic_pkg::token_t    tok_next;
    logic               eligible;
    logic               better;

    always_comb
    begin
        eligible = occupied && (data_reg.start_pt <= reach);
        better   = eligible && (!tok_in.found ||
                   (data_reg.end_pt > tok_in.iv.end_pt) ||
                   ((data_reg.end_pt == tok_in.iv.end_pt) &&
                    (data_reg.start_pt < tok_in.iv.start_pt)));
        if (better)
        begin
            tok_next.found = 1'b1;
            tok_next.iv    = data_reg;
        end
        else
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= tok_next.found;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= tok_next.iv;
        if (shift_en)
        begin
            data_reg <= data_in;
        end
    end

    assign data_out     = data_reg;
    assign tok_out.found = found_reg;
    assign tok_out.iv    = best_reg;

endmodule

FILE: hdl/gic_ctrl.sv
// sequencer of the cover: check pass, emit pass and the result register
`include "assert_macros.svh"

module gic_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_fire,
    input  logic                              in_final,
    input  logic signed [gic_pkg::DATA_W-1:0] target,
    input  logic                              ovf,
    input  gic_pkg::token_t                   tok,
    output logic                              in_ready,
    output gic_pkg::cmd_t                     cmd,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              status,
    output logic signed [gic_pkg::DATA_W-1:0] chosen_start,
    output logic signed [gic_pkg::DATA_W-1:0] chosen_end,
    output logic                              last_result,
    output logic                              overflowed
);

    localparam logic [gic_pkg::STEP_W-1:0] STEP_LAST = gic_pkg::STEP_W'(gic_pkg::NUM_CELLS - 1);

    gic_pkg::state_t                  state_reg, state_next;
    logic signed [gic_pkg::DATA_W-1:0] reach_reg, reach_next;
    logic [gic_pkg::STEP_W-1:0]        ctr_reg, ctr_next;
    logic                              emit_reg, emit_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              status_reg, status_next;
    logic signed [gic_pkg::DATA_W-1:0] start_reg, start_next;
    logic signed [gic_pkg::DATA_W-1:0] end_reg, end_next;
    logic                              last_reg, last_next;
    logic                              ovf_reg, ovf_next;
    logic                              load_out;
    logic                              clear;
    logic                              progress_ok;
    logic                              reached;
    logic                              out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gic_pkg::ST_LOAD;
            reach_reg     <= '0;
            ctr_reg       <= '0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            reach_reg     <= reach_next;
            ctr_reg       <= ctr_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        last_reg   <= last_next;
        ovf_reg    <= ovf_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        reach_next  = reach_reg;
        ctr_next    = ctr_reg;
        emit_next   = emit_reg;
        load_out    = 1'b0;
        clear       = 1'b0;
        status_next = status_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        last_next   = last_reg;
        ovf_next    = ovf_reg;

        // a step fails when nothing starts within reach or the best end adds nothing
        progress_ok = tok.found &&
                      !((tok.iv.end_pt < target) && (tok.iv.end_pt <= reach_reg));
        reached     = tok.iv.end_pt >= target;
        out_free    = !out_valid_reg || out_ready;

        case (state_reg)
            gic_pkg::ST_LOAD:
            begin
                if (in_fire && in_final)
                begin
                    state_next = gic_pkg::ST_SCAN;
                    reach_next = '0;
                    ctr_next   = '0;
                    emit_next  = 1'b0;
                end
            end
            gic_pkg::ST_SCAN:
            begin
                ctr_next = ctr_reg + 1'b1;
                if (ctr_reg == STEP_LAST)
                begin
                    state_next = gic_pkg::ST_DECIDE;
                end
            end
            gic_pkg::ST_DECIDE:
            begin
                if (!progress_ok)
                begin
                    if (out_free)
                    begin
                        load_out    = 1'b1;
                        status_next = 1'b1;
                        start_next  = '0;
                        end_next    = '0;
                        last_next   = 1'b1;
                        ovf_next    = ovf;
                        clear       = 1'b1;
                        state_next  = gic_pkg::ST_LOAD;
                    end
                end
                else if (!emit_reg)
                begin
                    // check pass: the cover is known to succeed once the target is reached
                    ctr_next   = '0;
                    state_next = gic_pkg::ST_SCAN;
                    if (reached)
                    begin
                        emit_next  = 1'b1;
                        reach_next = '0;
                    end
                    else
                    begin
                        reach_next = tok.iv.end_pt;
                    end
                end
                else if (out_free)
                begin
                    load_out    = 1'b1;
                    status_next = 1'b0;
                    start_next  = tok.iv.start_pt;
                    end_next    = tok.iv.end_pt;
                    last_next   = reached;
                    ovf_next    = ovf;
                    if (reached)
                    begin
                        clear      = 1'b1;
                        state_next = gic_pkg::ST_LOAD;
                    end
                    else
                    begin
                        reach_next = tok.iv.end_pt;
                        ctr_next   = '0;
                        state_next = gic_pkg::ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = gic_pkg::ST_LOAD;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_ready     = (state_reg == gic_pkg::ST_LOAD);
    assign cmd.clear    = clear;
    assign cmd.reach    = reach_reg;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign chosen_start = start_reg;
    assign chosen_end   = end_reg;
    assign last_result  = last_reg;
    assign overflowed   = ovf_reg;

    `GIC_ASSERT_NOW(a_fail_is_last, out_valid_reg && status_reg, last_reg)
    `GIC_ASSERT_NOW(a_fail_zero, out_valid_reg && status_reg, (start_reg == '0) && (end_reg == '0))
    `GIC_ASSERT_NEXT(a_scan_ends, (state_reg == gic_pkg::ST_SCAN) && (ctr_reg == STEP_LAST), state_reg == gic_pkg::ST_DECIDE)

endmodule

FILE: hdl/greedy_interval_cover.sv
// top level of the greedy interval cover: cell chain, fill count and target register
//
// input channel (in_valid/in_ready): one interval per transaction, start_point and
// end_point signed; final_item marks the last interval of a set and starts the cover.
// in the load state intervals enter one per cycle into a chain of 64 cells; once it
// is full, more intervals are dropped and all results of that set carry overflowed.
// configuration channel (cfg_valid/cfg_ready): writes target_end, always ready;
// write it only while no set is being covered.
// output channel (out_valid/out_ready): one transaction per chosen interval, in
// order, the last one flagged by last_result; a set that cannot be covered gives a
// single transaction with status high and zero start and end.
// each greedy step ripples a best-so-far token through all 64 cells during the scan
// state, then decides in the decide state. a check pass first walks the whole cover,
// then an emit pass walks it again and hands out the picks; a failure shows after
// the failing step.
// a stalled receiver holds the result register and stops the sequencer at its next
// pick; in_ready returns as soon as the last result is loaded into that register.
// reset empties the set, clears the overflow mark and sets target_end to zero.
`include "assert_macros.svh"

module greedy_interval_cover (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [gic_pkg::DATA_W-1:0] start_point,
    input  logic signed [gic_pkg::DATA_W-1:0] end_point,
    input  logic                              final_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic signed [gic_pkg::DATA_W-1:0] target_end,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              status,
    output logic signed [gic_pkg::DATA_W-1:0] chosen_start,
    output logic signed [gic_pkg::DATA_W-1:0] chosen_end,
    output logic                              last_result,
    output logic                              overflowed
);

    localparam logic [gic_pkg::CNT_W-1:0] FULL = gic_pkg::CNT_W'(gic_pkg::NUM_CELLS);

    logic [gic_pkg::CNT_W-1:0]         count_reg, count_next;
    logic                              ovf_reg, ovf_next;
    logic signed [gic_pkg::DATA_W-1:0] target_reg, target_next;
    logic                              in_fire;
    logic                              store_en;
    gic_pkg::cmd_t                     cmd;
    gic_pkg::interval_t                new_iv;
    gic_pkg::interval_t                cell_data [gic_pkg::NUM_CELLS];
    gic_pkg::token_t                   cell_tok  [gic_pkg::NUM_CELLS];

    assign in_fire         = in_valid && in_ready;
    assign store_en        = in_fire && (count_reg != FULL);
    assign cfg_ready       = 1'b1;
    assign new_iv.start_pt = start_point;
    assign new_iv.end_pt   = end_point;

    // fill count and overflow mark live until the sequencer finishes the set
    always_comb
    begin
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        target_next = target_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (store_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (in_fire)
        begin
            ovf_next = 1'b1;
        end
        if (cfg_valid && cfg_ready)
        begin
            target_next = target_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            target_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            target_reg <= target_next;
        end
    end

    // new intervals enter at cell 0 and push the others along; the best token
    // enters empty at cell 0 and leaves refined at the far end
    for (genvar i = 0; i < gic_pkg::NUM_CELLS; i++)
    begin : g_cell
        gic_pkg::interval_t link_data;
        gic_pkg::token_t    link_tok;
        logic               occupied;

        if (i == 0)
        begin : g_head
            assign link_data = new_iv;
            assign link_tok  = '0;
        end
        else
        begin : g_body
            assign link_data = cell_data[i-1];
            assign link_tok  = cell_tok[i-1];
        end

        assign occupied = (count_reg > gic_pkg::CNT_W'(i));

        gic_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (store_en),
            .occupied (occupied),
            .reach    (cmd.reach),
            .data_in  (link_data),
            .data_out (cell_data[i]),
            .tok_in   (link_tok),
            .tok_out  (cell_tok[i])
        );
    end

    gic_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .in_final     (final_item),
        .target       (target_reg),
        .ovf          (ovf_reg),
        .tok          (cell_tok[gic_pkg::NUM_CELLS-1]),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .chosen_start (chosen_start),
        .chosen_end   (chosen_end),
        .last_result  (last_result),
        .overflowed   (overflowed)
    );

    `GIC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FULL)

endmodule

FILE: tb/sv/tb_greedy_interval_cover.sv
// testbench for the greedy interval cover: directed and random sets against a cover model
module tb_greedy_interval_cover;

    typedef logic signed [gic_pkg::DATA_W-1:0] coord_t;

    // one result transaction as seen on the output channel
    typedef struct packed {
        logic   status;
        coord_t cstart;
        coord_t cend;
        logic   last;
        logic   ovf;
    } cover_result_t;

    localparam int MAX_PICKS     = 64;
    localparam int REPORT_LIMIT  = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 200;
    localparam int RANDOM_ITEMS  = 160;
    // worst case grows with the number of picks and with stalls; this limit leaves a wide margin
    localparam int CYCLE_LIMIT   = 1_000_000;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    coord_t start_point;
    coord_t end_point;
    logic   final_item;
    logic   cfg_valid;
    logic   cfg_ready;
    coord_t target_wdata;
    logic   out_valid;
    logic   out_ready = 1'b0;
    logic   status;
    coord_t chosen_start;
    coord_t chosen_end;
    logic   last_result;
    logic   overflowed;

    // cover model state: the set being loaded, its dropped mark and the target
    int            held_start[$];
    int            held_end[$];
    bit            held_dropped = 1'b0;
    int            cover_target = 0;
    cover_result_t pending_results[$];

    // intervals of the next set, in send order
    gic_pkg::interval_t batch[$];

    int mismatch_count   = 0;
    int cycle_count      = 0;
    int stall_left       = 0;
    bit input_gaps_on    = 1'b1;
    bit output_stalls_on = 1'b1;

    greedy_interval_cover dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_point  (start_point),
        .end_point    (end_point),
        .final_item   (final_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .target_end   (target_wdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .chosen_start (chosen_start),
        .chosen_end   (chosen_end),
        .last_result  (last_result),
        .overflowed   (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int clamp16(int x);
        if (x > 32767)
            return 32767;
        if (x < -32768)
            return -32768;
        return x;
    endfunction

    // greedy cover of the held set against the current target
    function automatic void plan_cover();
        int            reach;
        int            best;
        bit            found;
        bit            done;
        bit            failed;
        int            pick_s[$];
        int            pick_e[$];
        cover_result_t r;
        reach  = 0;
        failed = (held_start.size() == 0);
        done   = failed;
        while (!done)
        begin
            found = 1'b0;
            best  = 0;
            foreach (held_start[i])
            begin
                if (held_start[i] <= reach)
                begin
                    // greatest end wins, ties go to the smallest start
                    if (!found || held_end[i] > held_end[best] ||
                        (held_end[i] == held_end[best] && held_start[i] < held_start[best]))
                    begin
                        best  = i;
                        found = 1'b1;
                    end
                end
            end
            // nothing reachable, no progress, or too many picks
            if (!found || (held_end[best] < cover_target && held_end[best] <= reach) ||
                pick_s.size() >= MAX_PICKS)
            begin
                failed = 1'b1;
                done   = 1'b1;
            end
            else
            begin
                pick_s.insert(pick_s.size(), held_start[best]);
                pick_e.insert(pick_e.size(), held_end[best]);
                if (held_end[best] >= cover_target)
                    done = 1'b1;
                else
                    reach = held_end[best];
            end
        end
        if (failed)
        begin
            r = '{status: 1'b1, cstart: '0, cend: '0, last: 1'b1, ovf: held_dropped};
            pending_results.insert(pending_results.size(), r);
        end
        else
        begin
            foreach (pick_s[k])
            begin
                r.status = 1'b0;
                r.cstart = coord_t'(pick_s[k]);
                r.cend   = coord_t'(pick_e[k]);
                r.last   = (k == pick_s.size() - 1);
                r.ovf    = held_dropped;
                pending_results.insert(pending_results.size(), r);
            end
        end
    endfunction

    // model update for one accepted interval
    function automatic void stow_interval(coord_t s, coord_t e, logic fin);
        if (held_start.size() < gic_pkg::NUM_CELLS)
        begin
            held_start.insert(held_start.size(), int'(s));
            held_end.insert(held_end.size(), int'(e));
        end
        else
            held_dropped = 1'b1;
        if (fin)
        begin
            plan_cover();
            held_start.delete();
            held_end.delete();
            held_dropped = 1'b0;
        end
    endfunction

    function automatic void add_interval(int s, int e);
        gic_pkg::interval_t iv;
        iv.start_pt = coord_t'(s);
        iv.end_pt   = coord_t'(e);
        batch.insert(batch.size(), iv);
    endfunction

    // well-formed chain from 0 toward the target, at most cap links
    function automatic void add_chain(int tgt, int max_pieces, int cap);
        int reach;
        int step;
        int n;
        if (tgt <= 0)
        begin
            add_interval(-int'($urandom_range(0, 100)),
                         clamp16(tgt + int'($urandom_range(0, 100))));
            return;
        end
        step  = tgt / $urandom_range(1, max_pieces) + 1;
        reach = 0;
        n     = 0;
        while (reach < tgt && n < cap)
        begin
            add_interval(clamp16(reach - int'($urandom_range(0, step))),
                         clamp16(reach +
                                 int'($urandom_range(step / 2 + 1, step + step / 2 + 1))));
            reach = clamp16(reach + 1) > 32767 ? reach : batch[batch.size() - 1].end_pt;
            n++;
        end
    endfunction

    // random intervals; span 0 means the full 16-bit range
    function automatic void add_noise(int count, int span);
        for (int i = 0; i < count; i++)
        begin
            if (span == 0)
                add_interval(int'(coord_t'($urandom)), int'(coord_t'($urandom)));
            else
                add_interval(int'($urandom_range(0, 2 * span)) - span,
                             int'($urandom_range(0, 2 * span)) - span);
        end
    endfunction

    function automatic void mix_batch();
        int                 j;
        gic_pkg::interval_t tmp;
        for (int i = batch.size() - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = batch[i];
            batch[i] = batch[j];
            batch[j] = tmp;
        end
    endfunction

    function automatic int pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32767;
        else if (r < 20)
            return -32768;
        else if (r < 30)
            return 0;
        else if (r < 45)
            return -int'($urandom_range(1, 500));
        else if (r < 85)
            return int'($urandom_range(1, 2000));
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // one input transaction; valid stays up after acceptance so the next item
    // can follow with no bubble, the caller's next action lowers or reloads it
    task automatic send_interval(coord_t s, coord_t e, logic fin);
        int gap;
        gap = input_gaps_on ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        start_point <= s;
        end_point   <= e;
        final_item  <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        stow_interval(s, e, fin);
    endtask

    // sends the batch as one set, the last interval marked final
    task automatic send_batch();
        foreach (batch[i])
            send_interval(batch[i].start_pt, batch[i].end_pt, i == batch.size() - 1);
        batch.delete();
    endtask

    // wait until every predicted result has come back, then let the block settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // target write, only with the block idle
    task automatic write_target(int value);
        drain_results();
        cfg_valid    <= 1'b1;
        target_wdata <= coord_t'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cover_target = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // target still at its reset value of zero
    task automatic test_reset_target();
        add_interval(0, 0);
        send_batch();
        // end below a zero target makes no progress
        add_interval(-32768, -32768);
        send_batch();
    endtask

    // multi-step chain and tie breaking on equal ends
    task automatic test_greedy_choice();
        write_target(1000);
        add_interval(0, 300);
        add_interval(200, 700);
        add_interval(100, 250);
        add_interval(650, 1000);
        add_interval(600, 900);
        send_batch();
        write_target(50);
        add_interval(0, 50);
        add_interval(-5, 50);
        add_interval(-3, 50);
        add_interval(-5, 20);
        send_batch();
    endtask

    // nothing starts at or below zero, then a hole in the middle
    task automatic test_uncoverable();
        write_target(100);
        add_interval(5, 200);
        add_interval(1, 50);
        send_batch();
        add_interval(0, 10);
        add_interval(20, 100);
        send_batch();
    endtask

    // negative target with reversed intervals
    task automatic test_nonpositive_target();
        write_target(-50);
        add_interval(-20, -40);
        send_batch();
        add_interval(-5, -100);
        add_interval(3, 5);
        send_batch();
    endtask

    // field and target extremes
    task automatic test_extremes();
        write_target(32767);
        add_interval(-32768, 32767);
        add_interval(32767, -32768);
        send_batch();
        write_target(-32768);
        add_interval(32767, 32767);
        add_interval(0, -32768);
        send_batch();
    endtask

    // full store, every interval picked; run without idling
    task automatic test_full_chain();
        write_target(640);
        input_gaps_on    = 1'b0;
        output_stalls_on = 1'b0;
        for (int k = 0; k < gic_pkg::NUM_CELLS; k++)
            add_interval(k * 10, k * 10 + 10);
        mix_batch();
        send_batch();
        input_gaps_on    = 1'b1;
        output_stalls_on = 1'b1;
    endtask

    // two intervals beyond capacity, the final one among them, both would cover
    task automatic test_overflow();
        write_target(300);
        add_chain(300, 20, 40);
        add_noise(gic_pkg::NUM_CELLS - batch.size(), 400);
        mix_batch();
        add_interval(-1, 32767);
        add_interval(0, 32767);
        send_batch();
        // next set must come back with the overflow mark cleared
        add_interval(0, 300);
        send_batch();
    endtask

    // mostly well-formed chains with random content, some broken, some pure noise
    task automatic test_random_sets();
        int sent;
        int sets;
        int kind;
        sent = 0;
        sets = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sets % 6 == 0)
                write_target(pick_target());
            input_gaps_on    = ($urandom_range(0, 4) != 0);
            output_stalls_on = ($urandom_range(0, 4) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                add_chain(cover_target, 5, 12);
                add_noise($urandom_range(0, 3), cover_target > 100 ? cover_target : 100);
            end
            else if (kind < 80)
            begin
                // chain with one link missing
                add_chain(cover_target, 5, 12);
                if (batch.size() > 1)
                    batch.delete($urandom_range(0, batch.size() - 1));
                add_noise($urandom_range(0, 2), cover_target > 100 ? cover_target : 100);
            end
            else
                add_noise($urandom_range(1, 5), 0);
            mix_batch();
            sent += batch.size();
            send_batch();
            sets++;
        end
    endtask

    task automatic report_mismatch(string what, cover_result_t want, cover_result_t got);
        if (mismatch_count < REPORT_LIMIT)
        begin
            $write("mismatch (%s): expected st=%0b start=%0d end=%0d last=%0b ovf=%0b,",
                   what, want.status, want.cstart, want.cend, want.last, want.ovf);
            $display(" got st=%0b start=%0d end=%0d last=%0b ovf=%0b",
                     got.status, got.cstart, got.cend, got.last, got.ovf);
        end
        mismatch_count++;
    endtask

    // output ready with random stalls, sometimes long
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (output_stalls_on && $urandom_range(0, 3) == 0)
                stall_left = gap_len();
        end
    end

    // every result transaction against the oldest prediction
    always @(posedge clk)
    begin : check_results
        cover_result_t got;
        cover_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{status: status, cstart: chosen_start, cend: chosen_end,
                    last: last_result, ovf: overflowed};
            if (pending_results.size() == 0)
                report_mismatch("nothing expected", '0, got);
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got.status !== want.status || got.cstart !== want.cstart ||
                    got.cend !== want.cend || got.last !== want.last ||
                    got.ovf !== want.ovf)
                    report_mismatch("field", want, got);
            end
        end
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_greedy_interval_cover: FAIL");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        start_point  = '0;
        end_point    = '0;
        final_item   = 1'b0;
        cfg_valid    = 1'b0;
        target_wdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_target();
        test_greedy_choice();
        test_uncoverable();
        test_nonpositive_target();
        test_extremes();
        test_full_chain();
        test_overflow();
        test_random_sets();

        // everything back, then a quiet stretch to catch stray results
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb_greedy_interval_cover: PASS");
        else
            $display("tb_greedy_interval_cover: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/gic_pkg.sv
hdl/gic_cell.sv
hdl/gic_ctrl.sv
hdl/greedy_interval_cover.sv
tb/sv/tb_greedy_interval_cover.sv
